// File: rtl/cbm_pkg.sv
// shared constants and codes for the character bigram markov trainer and sampler
// no dependencies
`default_nettype none
package cbm_pkg;
  localparam int ALPHABET_SIZE_DEF = 256;
  localparam int COUNT_BITS_DEF    = 16;

  localparam logic [7:0] SEP_A_RESET = 8'd32;
  localparam logic [7:0] SEP_B_RESET = 8'd10;

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_SEP_A = 3'd0;
  localparam logic [CFG_AW-1:0] REG_SEP_B = 3'd4;

  localparam logic MODE_TRAIN = 1'b0;
  localparam logic MODE_GEN   = 1'b1;

  localparam logic [2:0] ST_ORIGIN  = 3'd0;
  localparam logic [2:0] ST_COUNTED = 3'd1;
  localparam logic [2:0] ST_SKIPPED = 3'd2;
  localparam logic [2:0] ST_SAT     = 3'd3;
  localparam logic [2:0] ST_GEN     = 3'd4;
  localparam logic [2:0] ST_NOSUCC  = 3'd5;
endpackage
`default_nettype wire

// File: rtl/char_bigram_markov_train_sample_core.sv
// character bigram markov chain: trainer and sampler, top level
// depends on cbm_pkg and cbm_ram
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser: mode; tdata: data_byte, random_value, start_word
// m_*      out  m_tvalid/m_tready  tuser: status; tdata: out_char
// apb      in   psel/penable       separator_a at 0x0, separator_b at 0x4
//
// one request at a time; the successor row of n entries is read one slot a cycle
// train: scan the row, then write; generate: sum, 31-step modulo, pick
// rate is set by the single read port of the successor memory
// reset clears control state and the row valid bits, no clearing pass
// the next request is taken while a result waits in the output register
`default_nettype none
module char_bigram_markov_train_sample_core
  import cbm_pkg::*;
#(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [39:0]       s_tdata,   // data_byte[7:0], random_value[38:8], start_word[39]
  input  wire logic              s_tuser,   // mode
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [7:0]        m_tdata,   // out_char
  output logic      [2:0]        m_tuser,   // status
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);
  localparam int SLOT_W = $clog2(ALPHABET_SIZE);
  localparam int N_W    = $clog2(ALPHABET_SIZE + 1);
  localparam int TOT_W  = COUNT_BITS + 9;
  localparam int ENT_W  = 8 + COUNT_BITS;
  localparam int SDEPTH = 256 << SLOT_W;
  localparam logic [COUNT_BITS-1:0] FREQ_MAX = {COUNT_BITS{1'b1}};
  localparam logic [N_W-1:0] ROW_CAP = N_W'(ALPHABET_SIZE);

  typedef enum logic [2:0] {
    S_IDLE, S_CNT, S_TSCAN, S_TWR, S_GSUM, S_DIV, S_GPICK, S_FIN
  } state_t;

  state_t state;
  logic [7:0] sep_a, sep_b;
  logic started;
  logic [7:0] origin, prev_char, cursor;
  logic [255:0] row_valid;

  logic mode_q;
  logic [7:0] byte_q, row;
  logic [30:0] rnd_sh;
  logic [N_W-1:0] n, issue_idx;
  logic chk_pend;
  logic [SLOT_W-1:0] chk_idx, hit_slot;
  logic hit;
  logic [COUNT_BITS-1:0] hit_freq;
  logic [TOT_W-1:0] total, rem, acc;
  logic [4:0] div_cnt;
  logic [7:0] last_char, res_char;
  logic [2:0] res_status;

  logic [7:0] row_in;
  logic [N_W-1:0] cnt_rdata, cnt_wdata;
  logic cnt_we;
  logic slot_we;
  logic [SLOT_W+7:0] slot_waddr, slot_raddr;
  logic [ENT_W-1:0] slot_wdata, slot_rdata;
  logic [7:0] rd_char;
  logic [COUNT_BITS-1:0] rd_freq;
  logic [TOT_W:0] rem_sh;
  logic [TOT_W-1:0] acc_new;
  logic [N_W-1:0] n_now;
  logic issue_more;

  assign row_in = (s_tuser == MODE_GEN) ? (s_tdata[39] ? origin : cursor) : prev_char;
  assign rd_char = slot_rdata[ENT_W-1:COUNT_BITS];
  assign rd_freq = slot_rdata[COUNT_BITS-1:0];
  assign n_now = row_valid[row] ? cnt_rdata : '0;
  assign issue_more = issue_idx < n;
  assign slot_raddr = {row, issue_idx[SLOT_W-1:0]};
  assign rem_sh = {rem, rnd_sh[30]};
  assign acc_new = acc + TOT_W'(rd_freq);

  always_comb begin
    slot_we    = (state == S_TWR) && (hit ? (hit_freq != FREQ_MAX) : (n != ROW_CAP));
    slot_waddr = {row, hit ? hit_slot : n[SLOT_W-1:0]};
    slot_wdata = hit ? {byte_q, hit_freq + COUNT_BITS'(1)} : {byte_q, COUNT_BITS'(1)};
    cnt_we     = (state == S_TWR) && !hit && (n != ROW_CAP);
    cnt_wdata  = n + N_W'(1);
  end

  cbm_ram #(.WIDTH(N_W), .DEPTH(256)) u_cnt_ram (
    .clk, .we(cnt_we), .waddr(row), .wdata(cnt_wdata), .raddr(row_in), .rdata(cnt_rdata)
  );

  cbm_ram #(.WIDTH(ENT_W), .DEPTH(SDEPTH)) u_slot_ram (
    .clk, .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  assign s_tready = (state == S_IDLE);
  assign pready = 1'b1;

  always_comb begin
    case (paddr)
      REG_SEP_A: prdata = {24'd0, sep_a};
      REG_SEP_B: prdata = {24'd0, sep_b};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sep_a     <= SEP_A_RESET;
      sep_b     <= SEP_B_RESET;
      started   <= 1'b0;
      origin    <= '0;
      prev_char <= '0;
      cursor    <= '0;
      row_valid <= '0;
      m_tvalid  <= 1'b0;
      chk_pend  <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr)
          REG_SEP_A: sep_a <= pwdata[7:0];
          REG_SEP_B: sep_b <= pwdata[7:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            mode_q  <= s_tuser;
            byte_q  <= s_tdata[7:0];
            rnd_sh  <= s_tdata[38:8];
            row     <= row_in;
            if (s_tuser == MODE_GEN && s_tdata[39]) begin
              cursor <= origin;
            end
            state <= S_CNT;
          end
        end
        S_CNT: begin
          n         <= n_now;
          issue_idx <= '0;
          chk_pend  <= 1'b0;
          total     <= '0;
          res_char  <= '0;
          if (mode_q == MODE_TRAIN) begin
            if (!started) begin
              started    <= 1'b1;
              origin     <= byte_q;
              prev_char  <= byte_q;
              cursor     <= byte_q;
              res_status <= ST_ORIGIN;
              state      <= S_FIN;
            end else if (byte_q == sep_a || byte_q == sep_b) begin
              res_status <= ST_SKIPPED;
              state      <= S_FIN;
            end else begin
              state <= S_TSCAN;
            end
          end else if (n_now == '0) begin
            res_status <= ST_NOSUCC;
            state      <= S_FIN;
          end else begin
            state <= S_GSUM;
          end
        end
        S_TSCAN: begin
          chk_pend <= issue_more;
          chk_idx  <= issue_idx[SLOT_W-1:0];
          if (issue_more) begin
            issue_idx <= issue_idx + N_W'(1);
          end
          if (chk_pend && rd_char == byte_q) begin
            hit      <= 1'b1;
            hit_slot <= chk_idx;
            hit_freq <= rd_freq;
            state    <= S_TWR;
          end else if (!issue_more) begin
            hit   <= 1'b0;
            state <= S_TWR;
          end
        end
        S_TWR: begin
          prev_char <= byte_q;
          if (hit) begin
            res_status <= (hit_freq == FREQ_MAX) ? ST_SAT : ST_COUNTED;
          end else if (n == ROW_CAP) begin
            res_status <= ST_SAT;
          end else begin
            res_status     <= ST_COUNTED;
            row_valid[row] <= 1'b1;
          end
          state <= S_FIN;
        end
        S_GSUM: begin
          chk_pend <= issue_more;
          if (issue_more) begin
            issue_idx <= issue_idx + N_W'(1);
          end
          if (chk_pend) begin
            total <= total + TOT_W'(rd_freq);
          end
          if (!issue_more && !chk_pend) begin
            rem     <= '0;
            div_cnt <= 5'd30;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rnd_sh <= rnd_sh << 1;
          if (rem_sh >= {1'b0, total}) begin
            rem <= TOT_W'(rem_sh - {1'b0, total});
          end else begin
            rem <= TOT_W'(rem_sh);
          end
          div_cnt <= div_cnt - 5'd1;
          if (div_cnt == '0) begin
            issue_idx <= '0;
            chk_pend  <= 1'b0;
            acc       <= '0;
            state     <= S_GPICK;
          end
        end
        S_GPICK: begin
          chk_pend <= issue_more;
          if (issue_more) begin
            issue_idx <= issue_idx + N_W'(1);
          end
          if (chk_pend) begin
            acc       <= acc_new;
            last_char <= rd_char;
          end
          if (chk_pend && rem < acc_new) begin
            res_char   <= rd_char;
            cursor     <= rd_char;
            res_status <= ST_GEN;
            state      <= S_FIN;
          end else if (!issue_more && !chk_pend) begin
            res_char   <= last_char;
            cursor     <= last_char;
            res_status <= ST_GEN;
            state      <= S_FIN;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_char;
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/cbm_ram.sv
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none
module cbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/cbm_checker.sv
// port level checks for the bigram markov core, bound to the top level
// depends on cbm_pkg
`default_nettype none
module cbm_checker
  import cbm_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic [7:0] m_tdata,
  input wire logic [2:0] m_tuser,
  input wire logic       m_tvalid,
  input wire logic       m_tready
);
  // one request in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("accepted while busy");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= ST_NOSUCC) else $error("bad status code");

  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_GEN |-> m_tdata == 8'd0) else $error("nonzero char");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result dropped");
endmodule

bind char_bigram_markov_train_sample_core cbm_checker u_cbm_checker (.*);
`default_nettype wire
